### design/cfcr_pkg.sv
package cfcr_pkg;

  localparam int CONFIG_BYTES = 640;
  localparam int MAX_PAYLOAD  = 656;

  // length width follows the payload limit; the index port is fixed; the counter takes the wider
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = 10;
  localparam int CNT_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  localparam logic [7:0]  HDR_FIRST  = 8'h5A;
  localparam logic [7:0]  HDR_SECOND = 8'hA5;
  localparam logic [7:0]  TAIL_FIRST = 8'hED;
  localparam logic [7:0]  TAIL_SECOND = 8'hDE;
  localparam logic [7:0]  CMD_READ   = 8'h01;
  localparam logic [7:0]  CMD_WRITE  = 8'h02;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_READ    = 2'd1;
  localparam logic [1:0] EV_WRITE   = 2'd2;
  localparam logic [1:0] EV_DISCARD = 2'd3;

  typedef struct packed {
    logic [1:0]       frame_event;
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
  } res_t;

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/crc_framed_command_receiver.sv
// Frame receiver for 5A A5 / command / 16-bit length / payload / CRC-16 MODBUS / ED DE
// frames, one serial byte per word. Every accepted byte yields exactly one result word:
// payload bytes are echoed with their index, and the last tail byte carries the frame
// event (read request, write commit or discard); an oversize length or a bad first tail byte
// carries a discard. Throughput is one byte per clock while rx_stall is low. The rate is set
// by the byte-wide CRC update and the parser step, which sit between the parser state and
// the result register. A two-word output stage (result register plus skid register) lets
// input bytes keep flowing while a result is held up; rx_stall rises only when both are full.
module crc_framed_command_receiver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_valid,
  output logic                        rx_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [1:0]                  frame_event,
  output logic                        payload_valid,
  output logic [7:0]                  payload_byte,
  output logic [cfcr_pkg::IDX_W-1:0]  payload_index
);

  typedef enum logic [9:0] {
    PH_H1  = 10'b00_0000_0001,
    PH_H2  = 10'b00_0000_0010,
    PH_CMD = 10'b00_0000_0100,
    PH_LL  = 10'b00_0000_1000,
    PH_LH  = 10'b00_0001_0000,
    PH_PAY = 10'b00_0010_0000,
    PH_CL  = 10'b00_0100_0000,
    PH_CH  = 10'b00_1000_0000,
    PH_T1  = 10'b01_0000_0000,
    PH_T2  = 10'b10_0000_0000
  } phase_t;

  phase_t                       phase, phase_next;
  logic [7:0]                   command_code, command_code_next;
  logic [7:0]                   length_low, length_low_next;
  logic [cfcr_pkg::LEN_W-1:0]   frame_length, frame_length_next;
  logic [cfcr_pkg::CNT_W-1:0]   byte_count, byte_count_next;
  logic [15:0]                  received_check, received_check_next;
  logic [15:0]                  running_check, running_check_next;
  logic [15:0]                  full_length;
  cfcr_pkg::res_t               res;
  cfcr_pkg::res_t               out_word, skid_word;
  logic                         out_valid, skid_valid;
  logic                         take;

  assign rx_stall = skid_valid;
  assign take     = rx_valid && !skid_valid;

  assign full_length = {rx_byte, length_low};

  always_comb begin
    phase_next          = phase;
    command_code_next   = command_code;
    length_low_next     = length_low;
    frame_length_next   = frame_length;
    byte_count_next     = byte_count;
    received_check_next = received_check;
    running_check_next  = running_check;
    res                 = '0;
    unique case (phase)
      PH_H1: begin
        if (rx_byte == cfcr_pkg::HDR_FIRST) phase_next = PH_H2;
      end
      PH_H2: begin
        phase_next = (rx_byte == cfcr_pkg::HDR_SECOND) ? PH_CMD : PH_H1;
      end
      PH_CMD: begin
        command_code_next = rx_byte;
        phase_next        = PH_LL;
      end
      PH_LL: begin
        length_low_next = rx_byte;
        phase_next      = PH_LH;
      end
      PH_LH: begin
        byte_count_next    = '0;
        running_check_next = cfcr_pkg::CRC_INIT;
        if (full_length > 16'(cfcr_pkg::MAX_PAYLOAD)) begin
          res.frame_event = cfcr_pkg::EV_DISCARD;
          phase_next      = PH_H1;
        end else begin
          frame_length_next = full_length[cfcr_pkg::LEN_W-1:0];
          phase_next        = (full_length != 16'd0) ? PH_PAY : PH_CL;
        end
      end
      PH_PAY: begin
        res.payload_valid  = 1'b1;
        res.payload_byte   = rx_byte;
        res.payload_index  = byte_count[cfcr_pkg::IDX_W-1:0];
        running_check_next = cfcr_pkg::crc_update(running_check, rx_byte);
        byte_count_next    = byte_count + 1'b1;
        if (byte_count_next >= cfcr_pkg::CNT_W'(frame_length)) phase_next = PH_CL;
      end
      PH_CL: begin
        received_check_next = {received_check[15:8], rx_byte};
        phase_next          = PH_CH;
      end
      PH_CH: begin
        received_check_next = {rx_byte, received_check[7:0]};
        phase_next          = PH_T1;
      end
      PH_T1: begin
        if (rx_byte == cfcr_pkg::TAIL_FIRST) begin
          phase_next = PH_T2;
        end else begin
          res.frame_event = cfcr_pkg::EV_DISCARD;
          phase_next      = PH_H1;
        end
      end
      PH_T2: begin
        res.frame_event = cfcr_pkg::EV_DISCARD;
        if (rx_byte == cfcr_pkg::TAIL_SECOND && running_check == received_check) begin
          if (command_code == cfcr_pkg::CMD_READ) begin
            res.frame_event = cfcr_pkg::EV_READ;
          end else if (command_code == cfcr_pkg::CMD_WRITE &&
                       16'(frame_length) == 16'(cfcr_pkg::CONFIG_BYTES)) begin
            res.frame_event = cfcr_pkg::EV_WRITE;
          end
        end
        phase_next = PH_H1;
      end
      default: begin
        phase_next = PH_H1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_H1;
      command_code   <= '0;
      length_low     <= '0;
      frame_length   <= '0;
      byte_count     <= '0;
      received_check <= '0;
      running_check  <= cfcr_pkg::CRC_INIT;
    end else if (take) begin
      phase          <= phase_next;
      command_code   <= command_code_next;
      length_low     <= length_low_next;
      frame_length   <= frame_length_next;
      byte_count     <= byte_count_next;
      received_check <= received_check_next;
      running_check  <= running_check_next;
    end
  end

  // output register with skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !res_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !res_stall) begin
      if (skid_valid) out_word <= skid_word;
      else if (take)  out_word <= res;
    end else if (take) begin
      skid_word <= res;
    end
  end

  assign res_valid     = out_valid;
  assign frame_event   = out_word.frame_event;
  assign payload_valid = out_word.payload_valid;
  assign payload_byte  = out_word.payload_byte;
  assign payload_index = out_word.payload_index;

endmodule

### design/cfcr_checker.sv
module cfcr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rx_valid,
  input logic                       rx_stall,
  input logic [7:0]                 rx_byte,
  input logic                       res_valid,
  input logic                       res_stall,
  input logic [1:0]                 frame_event,
  input logic                       payload_valid,
  input logic [7:0]                 payload_byte,
  input logic [cfcr_pkg::IDX_W-1:0] payload_index
);

  // a stalled input word stays on offer unchanged
  a_rx_hold: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
    else $error("input word changed while stalled");

  // a held result word keeps its contents
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(frame_event) &&
      $stable(payload_valid) && $stable(payload_byte) && $stable(payload_index))
    else $error("result word changed while stalled");

  // events only come on tail or length bytes, never with payload
  a_no_event_on_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && payload_valid |-> frame_event == cfcr_pkg::EV_NONE)
    else $error("event reported on a payload word");

  a_idle_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == '0)
    else $error("non-payload word carries payload data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !rx_stall)
    else $error("output stage not empty after reset");

endmodule

bind crc_framed_command_receiver cfcr_checker u_cfcr_checker (.*);

### tb/sv/crc_framed_command_receiver_tb.sv
`timescale 1ns / 100ps

module crc_framed_command_receiver_tb;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_TAIL1, FLAW_TAIL2, FLAW_TRUNC} flaw_t;

  localparam int ITEM_TARGET = 820;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 80;

  // frame parser prediction and the queue of result words it expects
  class cfcr_scoreboard;
    typedef enum logic [3:0] {
      ST_SYNC1, ST_SYNC2, ST_CMD, ST_LEN_LO, ST_LEN_HI,
      ST_DATA, ST_CRC_LO, ST_CRC_HI, ST_END1, ST_END2
    } stage_t;

    stage_t          stage;
    logic [7:0]      cmd_code;
    int              len_field;
    int              pay_count;
    logic [15:0]     frame_crc;
    logic [15:0]     calc_crc;
    cfcr_pkg::res_t  pending[$];
    int              errors;

    function new();
      stage     = ST_SYNC1;
      cmd_code  = '0;
      len_field = 0;
      pay_count = 0;
      frame_crc = '0;
      calc_crc  = cfcr_pkg::CRC_INIT;
      errors    = 0;
    endfunction

    // reflected MODBUS CRC, shifted one bit at a time
    static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c  = {1'b0, c[15:1]};
        if (fb) c = c ^ cfcr_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void note_byte(input logic [7:0] b);
      cfcr_pkg::res_t r;
      int             full;
      r = '0;
      case (stage)
        ST_SYNC1: begin
          if (b == cfcr_pkg::HDR_FIRST) stage = ST_SYNC2;
        end
        ST_SYNC2: begin
          stage = (b == cfcr_pkg::HDR_SECOND) ? ST_CMD : ST_SYNC1;
        end
        ST_CMD: begin
          cmd_code = b;
          stage    = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len_field = b;
          stage     = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          full      = len_field | (int'(b) << 8);
          pay_count = 0;
          calc_crc  = cfcr_pkg::CRC_INIT;
          if (full > cfcr_pkg::MAX_PAYLOAD) begin
            r.frame_event = cfcr_pkg::EV_DISCARD;
            stage         = ST_SYNC1;
          end else begin
            len_field = full;
            stage     = (full > 0) ? ST_DATA : ST_CRC_LO;
          end
        end
        ST_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = pay_count[cfcr_pkg::IDX_W-1:0];
          calc_crc        = crc_step(calc_crc, b);
          pay_count++;
          if (pay_count >= len_field) stage = ST_CRC_LO;
        end
        ST_CRC_LO: begin
          frame_crc = {8'h00, b};
          stage     = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          frame_crc[15:8] = b;
          stage           = ST_END1;
        end
        ST_END1: begin
          if (b == cfcr_pkg::TAIL_FIRST) begin
            stage = ST_END2;
          end else begin
            r.frame_event = cfcr_pkg::EV_DISCARD;
            stage         = ST_SYNC1;
          end
        end
        default: begin
          r.frame_event = cfcr_pkg::EV_DISCARD;
          if (b == cfcr_pkg::TAIL_SECOND && calc_crc == frame_crc) begin
            if (cmd_code == cfcr_pkg::CMD_READ) r.frame_event = cfcr_pkg::EV_READ;
            else if (cmd_code == cfcr_pkg::CMD_WRITE && len_field == cfcr_pkg::CONFIG_BYTES)
              r.frame_event = cfcr_pkg::EV_WRITE;
          end
          stage = ST_SYNC1;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(input cfcr_pkg::res_t got);
      cfcr_pkg::res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual %0h", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("frame_event", 16'(want.frame_event), 16'(got.frame_event));
      compare_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("payload_index", 16'(want.payload_index), 16'(got.payload_index));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       rx_valid = 1'b0;
  logic                       rx_stall;
  logic [7:0]                 rx_byte = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [1:0]                 frame_event;
  logic                       payload_valid;
  logic [7:0]                 payload_byte;
  logic [cfcr_pkg::IDX_W-1:0] payload_index;

  cfcr_scoreboard sb = new();
  int             bytes_sent = 0;
  bit             quiet_tx = 1'b0;
  bit             pressure_on = 1'b0;

  crc_framed_command_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .frame_event   (frame_event),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .payload_index (payload_index)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet_tx || pressure_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    sb.note_byte(b);
    bytes_sent++;
    if ($urandom_range(0, 63) == 0) quiet_tx = !quiet_tx;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int len, input flaw_t flaw);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    logic [7:0]  d;
    int          cut;
    crc     = cfcr_pkg::CRC_INIT;
    frame_q = '{cfcr_pkg::HDR_FIRST, cfcr_pkg::HDR_SECOND, cmd, len[7:0], len[15:8]};
    // an oversize length ends the frame at the header
    if (len <= cfcr_pkg::MAX_PAYLOAD) begin
      for (int k = 0; k < len; k++) begin
        d = 8'($urandom_range(0, 255));
        frame_q.push_back(d);
        crc = cfcr_scoreboard::crc_step(crc, d);
      end
      if (flaw == FLAW_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      frame_q.push_back((flaw == FLAW_TAIL1) ?
                        cfcr_pkg::TAIL_FIRST ^ 8'($urandom_range(1, 255)) :
                        cfcr_pkg::TAIL_FIRST);
      frame_q.push_back((flaw == FLAW_TAIL2) ?
                        cfcr_pkg::TAIL_SECOND ^ 8'($urandom_range(1, 255)) :
                        cfcr_pkg::TAIL_SECOND);
    end
    cut = frame_q.size();
    if (flaw == FLAW_TRUNC) cut = $urandom_range(3, frame_q.size() - 1);
    for (int k = 0; k < cut; k++) send_byte(frame_q[k]);
  endtask

  // result side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int stall_left;
    int hold_left;
    int results_seen;
    bit held;
    bit quiet_rx;
    int r;
    stall_left   = 0;
    hold_left    = 0;
    results_seen = 0;
    held         = 1'b0;
    quiet_rx     = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) begin
        sb.check_result({frame_event, payload_valid, payload_byte, payload_index});
        results_seen++;
      end
      if (!held && results_seen >= 40) begin
        held        = 1'b1;
        hold_left   = HOLD_CYCLES;
        pressure_on = 1'b1;
      end
      if ($urandom_range(0, 127) == 0) quiet_rx = !quiet_rx;
      if (hold_left > 0) begin
        hold_left--;
        pressure_on = (hold_left > 0);
        res_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && !quiet_rx && $urandom_range(0, 99) < 25) begin
          r = $urandom_range(0, 99);
          if (r < 70) stall_left = $urandom_range(1, 3);
          else if (r < 95) stall_left = $urandom_range(4, 10);
          else stall_left = $urandom_range(20, 50);
        end
        if (stall_left > 0) begin
          stall_left--;
          res_stall <= 1'b1;
        end else begin
          res_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) idle = 0;
      else idle++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int r;
    logic [7:0] cmd;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: noise, broken headers, every event and the main kinds of discard
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cfcr_pkg::HDR_SECOND);
    send_byte(cfcr_pkg::TAIL_FIRST);
    send_byte(cfcr_pkg::HDR_FIRST);
    send_byte(8'h00);
    send_byte(cfcr_pkg::HDR_FIRST);
    send_byte(cfcr_pkg::HDR_FIRST);
    send_byte(cfcr_pkg::HDR_SECOND);
    send_frame(cfcr_pkg::CMD_READ, 0, FLAW_NONE);
    send_frame(cfcr_pkg::CMD_READ, 3, FLAW_NONE);
    send_frame(cfcr_pkg::CMD_WRITE, cfcr_pkg::CONFIG_BYTES, FLAW_NONE);
    send_frame(cfcr_pkg::CMD_WRITE, 5, FLAW_NONE);
    send_frame(cfcr_pkg::CMD_READ, cfcr_pkg::MAX_PAYLOAD + 1, FLAW_NONE);
    send_frame(cfcr_pkg::CMD_READ, 4, FLAW_CRC);
    send_frame(cfcr_pkg::CMD_READ, 0, FLAW_TAIL1);
    send_frame(cfcr_pkg::CMD_READ, 2, FLAW_TAIL2);

    // random: small frames, many of them broken or oversize
    while (bytes_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 3);
      cmd = (r < 2) ? cfcr_pkg::CMD_READ :
            (r == 2) ? cfcr_pkg::CMD_WRITE : 8'($urandom_range(0, 255));
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
      r = $urandom_range(0, 99);
      if (r < 50) send_frame(cmd, len, FLAW_NONE);
      else if (r < 85) send_frame(cmd, len, flaw_t'($urandom_range(1, 4)));
      else if (r < 93) send_frame(cmd, $urandom_range(cfcr_pkg::MAX_PAYLOAD + 1, 65535),
                                  FLAW_NONE);
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
    rx_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
